// ===== src/pcpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page curl compositor package
// Shared widths, register indexes, color tables and pipeline types.
// ----------------------------------------------------------------------------
package pcpc_pkg;

	localparam int ROW_W       = 12;
	localparam int COL_W       = 12;
	localparam int DIM_W       = 13;
	localparam int COORD_W     = 20;
	localparam int DIFF_W      = COORD_W + 1;
	localparam int PIX_W       = 32;
	localparam int LOW_W       = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 20;
	localparam int MAX_DIM_DEF = 4096;

	// Products of the edge arithmetic and the compare operands.
	localparam int PROD_W = 45;
	localparam int MAG_W  = COORD_W;
	localparam int SCL_W  = DIM_W + MAG_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 3'd0,
		REG_IMAGE_HEIGHT = 3'd1,
		REG_W_X          = 3'd2,
		REG_W_Y          = 3'd3,
		REG_Z_X          = 3'd4,
		REG_Z_Y          = 3'd5,
		REG_S_X          = 3'd6,
		REG_UPSIDE_DOWN  = 3'd7
	} cfg_reg_t;

	typedef logic [7:0] lut5_t [32];
	typedef logic [7:0] lut6_t [64];

	function automatic lut5_t build_lut5();
		lut5_t lut;
		for (int k = 0; k < 32; k++) begin
			lut[k] = 8'(k * 255 / 31);
		end
		return lut;
	endfunction

	function automatic lut6_t build_lut6();
		lut6_t lut;
		for (int k = 0; k < 64; k++) begin
			lut[k] = 8'(k * 255 / 63);
		end
		return lut;
	endfunction

	localparam lut5_t C5_TO_8 = build_lut5();
	localparam lut6_t C6_TO_8 = build_lut6();

	// RGB565 to ABGR8888 with opaque alpha; blue lands in the byte above green.
	function automatic logic [PIX_W-1:0] to_argb(input logic [LOW_W-1:0] p);
		return {8'hFF, C5_TO_8[p[4:0]], C6_TO_8[p[10:5]], C5_TO_8[p[15:11]]};
	endfunction

	// Per-pixel fields that ride along with the edge arithmetic.
	typedef struct packed {
		logic             ok;
		logic             empty;
		logic             col_last;
		logic             col_nz;
		logic [PIX_W-1:0] existing;
		logic [PIX_W-1:0] argb;
	} pass_t;

endpackage

// ===== src/pcpc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page curl compositor channels
// Pixel request channel and composite result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pcpc_pix_in_if;
	import pcpc_pkg::*;

	logic                valid;
	logic                ready;
	logic [ROW_W-1:0]    row;
	logic [COL_W-1:0]    col;
	logic [PIX_W-1:0]    existing_pixel;
	logic [LOW_W-1:0]    lower_pixel;

	modport source (output valid, row, col, existing_pixel, lower_pixel, input ready);
	modport sink (input valid, row, col, existing_pixel, lower_pixel, output ready);
endinterface

interface pcpc_pix_out_if;
	import pcpc_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] out_pixel;
	logic             was_written;

	modport source (output valid, out_pixel, was_written, input ready);
	modport sink (input valid, out_pixel, was_written, output ready);
endinterface

// ===== src/page_curl_pixel_compositor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page curl pixel compositor
// Fills empty composite pixels right of the fold edge with the lower page.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake       Contents
//  pix_in    sink       valid/ready     row, col, existing_pixel, lower_pixel
//  pix_out   source     valid/ready     out_pixel, was_written
//  cfg       sink       cfg_we only     cfg_idx, cfg_data
//
// One pixel per cycle while pix_out takes results; a request taken on pix_in passes through stages s1 to s6 to pix_out.
// The depth is set by the edge test: differences, five multipliers, three sums
// and two compares against scaled column products.
// Reset clears the stage valid bits and loads the register defaults.
// Each stage holds while the stage after it is full and stalled, so bubbles
// close up and pix_in stays ready until all six stages are occupied and pix_out stalls.
// ----------------------------------------------------------------------------
module page_curl_pixel_compositor #(
	parameter int MAX_DIM = pcpc_pkg::MAX_DIM_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pcpc_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [pcpc_pkg::CFG_DATA_W-1:0] cfg_data,
	pcpc_pix_in_if.sink                     pix_in,
	pcpc_pix_out_if.source                  pix_out
);
	import pcpc_pkg::*;

	localparam int PAD_W = PROD_W - SCL_W - 4;

	// Configuration registers.
	logic [DIM_W-1:0]   image_width_q;
	logic [DIM_W-1:0]   image_height_q;
	logic [COORD_W-1:0] w_x_q;
	logic [COORD_W-1:0] w_y_q;
	logic [COORD_W-1:0] z_x_q;
	logic [COORD_W-1:0] z_y_q;
	logic [COORD_W-1:0] s_x_q;
	logic               upside_down_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= DIM_W'(1);
			image_height_q <= DIM_W'(1);
			w_x_q          <= '0;
			w_y_q          <= '0;
			z_x_q          <= '0;
			z_y_q          <= '0;
			s_x_q          <= '0;
			upside_down_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data[DIM_W-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data[DIM_W-1:0];
				REG_W_X:          w_x_q          <= cfg_data[COORD_W-1:0];
				REG_W_Y:          w_y_q          <= cfg_data[COORD_W-1:0];
				REG_Z_X:          z_x_q          <= cfg_data[COORD_W-1:0];
				REG_Z_Y:          z_y_q          <= cfg_data[COORD_W-1:0];
				REG_S_X:          s_x_q          <= cfg_data[COORD_W-1:0];
				REG_UPSIDE_DOWN:  upside_down_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Dimensions above MAX_DIM count as MAX_DIM.
	logic [DIM_W-1:0] wid_eff;
	logic [DIM_W-1:0] hgt_eff;

	always_comb begin
		wid_eff = image_width_q;
		hgt_eff = image_height_q;
		if (32'(image_width_q) > MAX_DIM) begin
			wid_eff = DIM_W'(MAX_DIM);
		end
		if (32'(image_height_q) > MAX_DIM) begin
			hgt_eff = DIM_W'(MAX_DIM);
		end
	end

	// Stage valids and enables; a stage moves when it is empty or its successor moves.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;

	assign en_s6 = !v_s6 || pix_out.ready;
	assign en_s5 = !v_s5 || en_s6;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign pix_in.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= pix_in.valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
		end
	end

	// Stage 1: range checks, effective row, color conversion, coordinate differences.
	logic                    in_ok;
	logic [ROW_W-1:0]        row_eff;
	pass_t                   pass_in;

	always_comb begin
		in_ok = (wid_eff != '0) && (hgt_eff != '0)
			&& ({1'b0, pix_in.row} < hgt_eff) && ({1'b0, pix_in.col} < wid_eff);
		row_eff = upside_down_q ? ROW_W'(hgt_eff - DIM_W'(1) - {1'b0, pix_in.row})
			: pix_in.row;
		pass_in.ok       = in_ok;
		pass_in.empty    = (pix_in.existing_pixel == '0);
		pass_in.col_last = ({1'b0, pix_in.col} == (wid_eff - DIM_W'(1)));
		pass_in.col_nz   = (pix_in.col != '0);
		pass_in.existing = pix_in.existing_pixel;
		pass_in.argb     = to_argb(pix_in.lower_pixel);
	end

	pass_t                   pass_s1, pass_s2, pass_s3, pass_s4, pass_s5;
	logic [ROW_W-1:0]        row_s1;
	logic [COL_W-1:0]        col_s1;
	logic signed [DIFF_W-1:0] den_s1, dx_s1, sdx_s1;

	// Stage 2: sign folding so the divisor is positive.
	logic signed [DIFF_W-1:0] t_s2, dxs_s2, sdx_s2;
	logic [MAG_W-1:0]         absden_s2;
	logic                     den_zero_s2, den_zero_s3, den_zero_s4, den_zero_s5;
	logic [DIM_W-1:0]         cp1_s2, cp2_s2;

	// Stage 3: products.
	logic signed [PROD_W-1:0] pa_s3, pb_s3, pc_s3;
	logic [SCL_W-1:0]         m1_s3, m2_s3, m1_s4, m2_s4, m2_s5;

	// Stage 4 and 5: numerators and the first compare.
	logic signed [PROD_W-1:0] n_s4, q_s4, pb_s4, n2_s5;
	logic                     c1_s5;

	// Stage 6: second compare and result.
	logic                     c2;
	logic                     wr;
	logic [PIX_W-1:0]         out_pixel_s6;
	logic                     was_written_s6;

	// The edge test without division: column k passes when N < (k + 1) * 16 * |den|.
	assign c2 = n2_s5 < $signed({{PAD_W{1'b0}}, m2_s5, 4'b0000});
	assign wr = pass_s5.ok && pass_s5.empty
		&& (den_zero_s5 || c1_s5 || pass_s5.col_last || (pass_s5.col_nz && c2));

	always_ff @(posedge clk) begin
		if (en_s1) begin
			pass_s1 <= pass_in;
			row_s1  <= row_eff;
			col_s1  <= pix_in.col;
			den_s1  <= $signed({z_y_q[COORD_W-1], z_y_q}) - $signed({w_y_q[COORD_W-1], w_y_q});
			dx_s1   <= $signed({z_x_q[COORD_W-1], z_x_q}) - $signed({w_x_q[COORD_W-1], w_x_q});
			sdx_s1  <= $signed({s_x_q[COORD_W-1], s_x_q}) - $signed({w_x_q[COORD_W-1], w_x_q});
		end
		if (en_s2) begin
			pass_s2     <= pass_s1;
			t_s2        <= $signed({{(DIFF_W - ROW_W - 4){1'b0}}, row_s1, 4'b0000})
				- $signed({z_y_q[COORD_W-1], z_y_q});
			absden_s2   <= den_s1[DIFF_W-1] ? MAG_W'(-den_s1) : MAG_W'(den_s1);
			dxs_s2      <= den_s1[DIFF_W-1] ? -dx_s1 : dx_s1;
			sdx_s2      <= sdx_s1;
			den_zero_s2 <= (den_s1 == '0);
			cp1_s2      <= {1'b0, col_s1} + DIM_W'(1);
			cp2_s2      <= {1'b0, col_s1} + DIM_W'(2);
		end
		if (en_s3) begin
			pass_s3     <= pass_s2;
			den_zero_s3 <= den_zero_s2;
			pa_s3       <= PROD_W'($signed(z_x_q) * $signed({1'b0, absden_s2}));
			pb_s3       <= PROD_W'(t_s2 * dxs_s2);
			pc_s3       <= PROD_W'(sdx_s2 * $signed({1'b0, absden_s2}));
			m1_s3       <= cp2_s2 * absden_s2;
			m2_s3       <= cp1_s2 * absden_s2;
		end
		if (en_s4) begin
			pass_s4     <= pass_s3;
			den_zero_s4 <= den_zero_s3;
			n_s4        <= pa_s3 + pb_s3;
			q_s4        <= pa_s3 + pc_s3;
			pb_s4       <= pb_s3;
			m1_s4       <= m1_s3;
			m2_s4       <= m2_s3;
		end
		if (en_s5) begin
			pass_s5     <= pass_s4;
			den_zero_s5 <= den_zero_s4;
			n2_s5       <= q_s4 + pb_s4;
			c1_s5       <= n_s4 < $signed({{PAD_W{1'b0}}, m1_s4, 4'b0000});
			m2_s5       <= m2_s4;
		end
		if (en_s6) begin
			out_pixel_s6   <= wr ? pass_s5.argb : pass_s5.existing;
			was_written_s6 <= wr;
		end
	end

	assign pix_out.valid       = v_s6;
	assign pix_out.out_pixel   = out_pixel_s6;
	assign pix_out.was_written = was_written_s6;

endmodule

// ===== src/pcpc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page curl compositor checker
// Port-level properties of the compositor, attached by bind.
// ----------------------------------------------------------------------------
module pcpc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [pcpc_pkg::PIX_W-1:0]  out_pixel,
	input logic                        was_written
);
	import pcpc_pkg::*;

	// A stalled result keeps its contents.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_pixel) && $stable(was_written))
		else $error("result changed while stalled");

	// A filled pixel is always opaque.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && was_written |-> out_pixel[PIX_W-1:PIX_W-8] == 8'hFF)
		else $error("written pixel without full alpha");

	// Nothing comes out right after reset.
	assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> !out_valid)
		else $error("result present right after reset");

	// With the output never stalled in between, an accepted request comes out of the pipeline.
	assert property (@(posedge clk) disable iff (!arst_n)
		$past(in_valid && in_ready, 6) && $past(out_ready, 1) && $past(out_ready, 2)
		&& $past(out_ready, 3) && $past(out_ready, 4) && $past(out_ready, 5)
		&& $past(arst_n, 1) && $past(arst_n, 2) && $past(arst_n, 3)
		&& $past(arst_n, 4) && $past(arst_n, 5) && $past(arst_n, 6)
		|-> out_valid)
		else $error("request lost in the pipeline");

endmodule

bind page_curl_pixel_compositor pcpc_checker u_pcpc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (pix_in.valid),
	.in_ready    (pix_in.ready),
	.out_valid   (pix_out.valid),
	.out_ready   (pix_out.ready),
	.out_pixel   (pix_out.out_pixel),
	.was_written (pix_out.was_written)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page curl pixel compositor testbench
// Streams pixel requests through the compositor under several fold geometries
// and image sizes, with random gaps on both channels. Each composite result is
// checked against a local computation of the fold edges and RGB565 expansion.
// ----------------------------------------------------------------------------
module testbench;
	import pcpc_pkg::*;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [PIX_W-1:0] existing;
		logic [LOW_W-1:0] lower;
	} pixel_req_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             written;
	} composite_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	pcpc_pix_in_if  pix_in_bus ();
	pcpc_pix_out_if pix_out_bus ();

	page_curl_pixel_compositor u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.pix_in   (pix_in_bus),
		.pix_out  (pix_out_bus)
	);

	// Local copy of the register file.
	logic [DIM_W-1:0]          cfg_width  = 13'd1;
	logic [DIM_W-1:0]          cfg_height = 13'd1;
	logic signed [COORD_W-1:0] cfg_wx     = '0;
	logic signed [COORD_W-1:0] cfg_wy     = '0;
	logic signed [COORD_W-1:0] cfg_zx     = '0;
	logic signed [COORD_W-1:0] cfg_zy     = '0;
	logic signed [COORD_W-1:0] cfg_sx     = '0;
	logic                      cfg_upside = 1'b0;

	pixel_req_t pixel_q[$];
	composite_t composite_q[$];
	pixel_req_t on_bus;
	int         accepted_count = 0;
	int         errors = 0;
	int         send_gap = 0;
	int         sink_gap = 0;
	bit         idle_en = 1'b1;
	bit         hold_sink = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic longint clamp_edge(longint q, longint wd);
		q = q - 1;
		if (q < 0) q = 0;
		if (q >= wd) q = wd - 1;
		return q;
	endfunction

	function automatic composite_t composite_pixel(pixel_req_t p);
		composite_t res;
		longint wd, ht, rw, cl, i, wx, wy, zx, zy, sx, den, num, num2, e1, e2, first_col;
		int r8, g8, b8;
		res.pixel = p.existing;
		res.written = 1'b0;
		wd = (cfg_width > MAX_DIM_DEF) ? MAX_DIM_DEF : cfg_width;
		ht = (cfg_height > MAX_DIM_DEF) ? MAX_DIM_DEF : cfg_height;
		rw = longint'(p.row);
		cl = longint'(p.col);
		if (wd == 0 || ht == 0 || rw >= ht || cl >= wd) return res;
		i = cfg_upside ? ht - 1 - rw : rw;
		wx = cfg_wx;
		wy = cfg_wy;
		zx = cfg_zx;
		zy = cfg_zy;
		sx = cfg_sx;
		e1 = 0;
		e2 = 0;
		den = zy - wy;
		// A horizontal fold line leaves both edges at column zero.
		if (den != 0) begin
			num = zx * den + (16 * i - zy) * (zx - wx);
			num2 = num + (sx - wx) * den;
			e1 = clamp_edge(num / (16 * den), wd);
			e2 = clamp_edge(num2 / (16 * den), wd);
		end
		first_col = (e2 + 1 < e1) ? e2 + 1 : e1;
		if (cl >= first_col && p.existing == 0) begin
			r8 = int'(p.lower[15:11]) * 255 / 31;
			g8 = int'(p.lower[10:5]) * 255 / 63;
			b8 = int'(p.lower[4:0]) * 255 / 31;
			res.pixel = {8'hFF, b8[7:0], g8[7:0], r8[7:0]};
			res.written = 1'b1;
		end
		return res;
	endfunction

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [DIM_W-1:0] pick_dim();
		int r;
		r = $urandom_range(0, 9);
		if (r < 8) return DIM_W'($urandom_range(1, 40));
		if (r == 8) return 13'd4096;
		return DIM_W'($urandom_range(1, 4096));
	endfunction

	// Coordinates mostly land around the image so the fold crosses it.
	function automatic logic [COORD_W-1:0] pick_coord(int span);
		int v;
		if ($urandom_range(0, 4) == 0) return COORD_W'($urandom);
		v = int'($urandom_range(0, 3 * span)) - span;
		return v[COORD_W-1:0];
	endfunction

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		case (idx)
			REG_IMAGE_WIDTH:  cfg_width = val[DIM_W-1:0];
			REG_IMAGE_HEIGHT: cfg_height = val[DIM_W-1:0];
			REG_W_X:          cfg_wx = val;
			REG_W_Y:          cfg_wy = val;
			REG_Z_X:          cfg_zx = val;
			REG_Z_Y:          cfg_zy = val;
			REG_S_X:          cfg_sx = val;
			REG_UPSIDE_DOWN:  cfg_upside = val[0];
			default: ;
		endcase
	endtask

	task automatic set_geometry(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h,
			logic [COORD_W-1:0] wx, logic [COORD_W-1:0] wy, logic [COORD_W-1:0] zx,
			logic [COORD_W-1:0] zy, logic [COORD_W-1:0] sx, logic ud);
		write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
		write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
		write_reg(REG_W_X, wx);
		write_reg(REG_W_Y, wy);
		write_reg(REG_Z_X, zx);
		write_reg(REG_Z_Y, zy);
		write_reg(REG_S_X, sx);
		write_reg(REG_UPSIDE_DOWN, CFG_DATA_W'(ud));
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic add_pixel(logic [ROW_W-1:0] r, logic [COL_W-1:0] c,
			logic [PIX_W-1:0] e, logic [LOW_W-1:0] l);
		pixel_q.push_back('{row: r, col: c, existing: e, lower: l});
	endtask

	task automatic drain();
		while (pixel_q.size() != 0 || pix_in_bus.valid || composite_q.size() != 0)
			@(negedge clk);
	endtask

	// Request side: predicts each accepted request, then offers the next one.
	always @(posedge clk) begin
		if (!arst_n) begin
			pix_in_bus.valid <= 1'b0;
		end else begin
			if (pix_in_bus.valid && pix_in_bus.ready) begin
				composite_q.push_back(composite_pixel(on_bus));
				accepted_count++;
			end
			if (!pix_in_bus.valid || pix_in_bus.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					pix_in_bus.valid <= 1'b0;
				end else if (pixel_q.size() != 0) begin
					on_bus = pixel_q.pop_front();
					pix_in_bus.row <= on_bus.row;
					pix_in_bus.col <= on_bus.col;
					pix_in_bus.existing_pixel <= on_bus.existing;
					pix_in_bus.lower_pixel <= on_bus.lower;
					pix_in_bus.valid <= 1'b1;
					if (idle_en) send_gap = pick_gap();
				end else begin
					pix_in_bus.valid <= 1'b0;
				end
			end
		end
	end

	// Result side: checks each accepted result against the oldest prediction.
	always @(posedge clk) begin : result_side
		composite_t want;
		if (!arst_n) begin
			pix_out_bus.ready <= 1'b0;
		end else begin
			if (pix_out_bus.valid && pix_out_bus.ready) begin
				if (composite_q.size() == 0) begin
					$display("%0t: unexpected result, actual %h written %b", $time,
						pix_out_bus.out_pixel, pix_out_bus.was_written);
					errors++;
				end else begin
					want = composite_q.pop_front();
					if (pix_out_bus.out_pixel !== want.pixel) begin
						$display("%0t: out_pixel mismatch, expected %h, actual %h", $time,
							want.pixel, pix_out_bus.out_pixel);
						errors++;
					end
					if (pix_out_bus.was_written !== want.written) begin
						$display("%0t: was_written mismatch, expected %b, actual %b", $time,
							want.written, pix_out_bus.was_written);
						errors++;
					end
				end
			end
			if (hold_sink) begin
				pix_out_bus.ready <= 1'b0;
			end else if (sink_gap > 0) begin
				pix_out_bus.ready <= 1'b0;
				sink_gap--;
			end else begin
				pix_out_bus.ready <= 1'b1;
				if (idle_en && $urandom_range(0, 3) == 0) sink_gap = pick_gap();
			end
		end
	end

	// Stall the results for a long stretch so the pipeline fills and backs up.
	initial begin
		wait (accepted_count >= 500);
		@(negedge clk);
		hold_sink = 1'b1;
		repeat (100) @(negedge clk);
		hold_sink = 1'b0;
	end

	initial begin : stimulus
		int w, h, span;
		logic [COORD_W-1:0] wy;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		pix_in_bus.valid = 1'b0;
		pix_in_bus.row = '0;
		pix_in_bus.col = '0;
		pix_in_bus.existing_pixel = '0;
		pix_in_bus.lower_pixel = '0;
		pix_out_bus.ready = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Register defaults: a single-pixel image.
		add_pixel(0, 0, 0, 16'hFFFF);
		add_pixel(0, 1, 0, 16'hFFFF);
		drain();

		// Diagonal fold across a 16x16 image.
		set_geometry(16, 16, 80, 0, 160, 240, 128, 1'b0);
		add_pixel(0, 0, 0, 16'h0000);
		add_pixel(0, 15, 0, 16'hFFFF);
		add_pixel(15, 15, 0, 16'hFFFF);
		add_pixel(7, 8, 0, 16'hF800);
		add_pixel(7, 12, 0, 16'h07E0);
		add_pixel(10, 14, 0, 16'h001F);
		add_pixel(3, 15, 32'hFFFF_FFFF, 16'hFFFF);
		add_pixel(5, 16, 0, 16'hFFFF);
		add_pixel(16, 3, 0, 16'hFFFF);
		add_pixel(12'hFFF, 12'hFFF, 0, 16'hFFFF);
		add_pixel(12, 9, 32'h0000_0001, 16'h1234);
		drain();

		// Same fold with the rows mirrored.
		set_geometry(16, 16, 80, 0, 160, 240, 128, 1'b1);
		add_pixel(0, 15, 0, 16'hFFFF);
		add_pixel(15, 10, 0, 16'h1234);
		add_pixel(15, 0, 0, 16'hFFFF);
		drain();

		// Horizontal fold line.
		set_geometry(16, 16, 50, 100, 200, 100, 30, 1'b0);
		add_pixel(0, 0, 0, 16'hABCD);
		add_pixel(9, 5, 0, 16'h5555);
		drain();

		// Zero width, then zero height.
		set_geometry(0, 16, 80, 0, 160, 240, 128, 1'b0);
		add_pixel(0, 0, 0, 16'hFFFF);
		drain();
		set_geometry(16, 0, 80, 0, 160, 240, 128, 1'b0);
		add_pixel(0, 0, 0, 16'hFFFF);
		drain();

		// Largest image with coordinates at their limits.
		set_geometry(4096, 4096, 20'h80000, 20'h7FFFF, 20'h7FFFF, 20'h80000, 20'h80000, 1'b1);
		add_pixel(0, 0, 0, 16'hFFFF);
		add_pixel(4095, 4095, 0, 16'hFFFF);
		add_pixel(2048, 100, 0, 16'hAAAA);
		add_pixel(100, 2048, 0, 16'h5555);
		drain();

		for (int ph = 0; ph < 10; ph++) begin
			idle_en = (ph % 4 != 3);
			w = int'(pick_dim());
			h = int'(pick_dim());
			span = ((w > h) ? w : h) * 16;
			wy = pick_coord(span);
			set_geometry(DIM_W'(w), DIM_W'(h), pick_coord(span), wy, pick_coord(span),
				($urandom_range(0, 9) == 0) ? wy : pick_coord(span),
				pick_coord(span), 1'($urandom_range(0, 1)));
			for (int k = 0; k < 153; k++) begin
				add_pixel(
					ROW_W'(($urandom_range(0, 3) == 0) ? $urandom
						: $urandom_range(0, (h > 4095) ? 4095 : h)),
					COL_W'(($urandom_range(0, 3) == 0) ? $urandom
						: $urandom_range(0, (w > 4095) ? 4095 : w)),
					$urandom_range(0, 1) ? 32'h0 : $urandom,
					LOW_W'($urandom));
			end
			// The sender waits here until every result of this geometry is back.
			drain();
		end

		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule

// ===== sim.f =====
src/pcpc_pkg.sv
src/pcpc_if.sv
src/page_curl_pixel_compositor.sv
src/pcpc_checker.sv
tb/testbench.sv
